@@ sv/bignum_single_limb_mul_div_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the single-limb multiply/divide unit
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BIGNUM_SINGLE_LIMB_MUL_DIV_UNIT_ASSERT_SVH
`define BIGNUM_SINGLE_LIMB_MUL_DIV_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge outside reset.
`define BSL_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("bsl: invariant violated");

// A condition that must hold in the cycle after a trigger.
`define BSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsl: next-cycle check failed");

`else

`define BSL_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define BSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/bsl_pkg.sv @@
// ----------------------------------------------------------------------------
// Shared package for the single-limb multiply/divide unit
// Sizes, operation codes, sequencer states and the arithmetic unit interface.
// ----------------------------------------------------------------------------
package bsl_pkg;

    // Store geometry.
    localparam int LIMB_CAPACITY = 128;
    localparam int LIMB_W        = 32;
    localparam int ADDR_W        = $clog2(LIMB_CAPACITY);
    localparam int CNT_W         = $clog2(LIMB_CAPACITY + 1);
    localparam int STEP_W        = $clog2(LIMB_W);

    // Fixed field widths of the transaction ports.
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 7;
    localparam int TOTAL_W  = 8;
    localparam int BITLEN_W = 13;

    // Internal widths for comparing a limb index and for the bit length.
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int BLC_W = CNT_W + STEP_W;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_MULADD = 2'd1,
        OP_DIVIDE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    // Commands to the shared arithmetic unit.
    typedef enum logic [2:0] {
        AOP_HOLD,
        AOP_INIT,
        AOP_MUL,
        AOP_ACC,
        AOP_LOAD,
        AOP_STEP
    } t_arith_op;

    // Status returned by the arithmetic unit.
    typedef struct packed {
        logic [LIMB_W-1:0] mul_lo;
        logic [LIMB_W-1:0] carry;
        logic [LIMB_W-1:0] quo;
        logic [LIMB_W-1:0] rem;
        logic              div_last;
    } t_arith_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_MPY,
        ST_MUL_ACC,
        ST_MUL_TAIL,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_DIV_WRITE,
        ST_RD_WAIT,
        ST_FIN
    } t_state;

    // Number of significant bits in one limb, 0 for a zero limb.
    function automatic logic [STEP_W:0] limb_bits(input logic [LIMB_W-1:0] v);
        logic [STEP_W:0] k;
        k = '0;
        for (int i = 0; i < LIMB_W; i++) begin
            if (v[i]) begin
                k = (STEP_W + 1)'(i + 1);
            end
        end
        return k;
    endfunction

endpackage

@@ sv/bsl_limb_ram.sv @@
// ----------------------------------------------------------------------------
// Limb store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bsl_limb_ram import bsl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [LIMB_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [LIMB_W-1:0] o_rdata
);

    logic [LIMB_W-1:0] r_mem [LIMB_CAPACITY];
    logic [LIMB_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data valid in the cycle after the address.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/bsl_arith_unit.sv @@
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// A 32x32 multiplier with carry accumulate, and a bit-serial restoring
// divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsl_arith_unit import bsl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_arith_op         i_ctrl,
    input  logic [LIMB_W-1:0] i_rd_data,
    input  logic [LIMB_W-1:0] i_factor,
    input  logic [LIMB_W-1:0] i_addend,
    output t_arith_stat       o_stat
);

    logic [2*LIMB_W-1:0] r_prod;
    logic [LIMB_W-1:0]   r_carry;
    logic [LIMB_W-1:0]   r_rem;
    logic [LIMB_W-1:0]   r_dq;
    logic [STEP_W-1:0]   r_step;

    logic [2*LIMB_W-1:0] sum;
    logic [LIMB_W:0]     trial;
    logic [LIMB_W:0]     diff;
    logic                ge;

    // Product plus incoming carry; cannot overflow 64 bits.
    assign sum = r_prod + {{LIMB_W{1'b0}}, r_carry};

    // One restoring division step on the partial remainder.
    assign trial = {r_rem, r_dq[LIMB_W-1]};
    assign diff  = trial - {1'b0, i_factor};
    assign ge    = (trial >= {1'b0, i_factor});

    // Step counter is control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_ctrl == AOP_LOAD) begin
            r_step <= '0;
        end else if (i_ctrl == AOP_STEP) begin
            r_step <= r_step + STEP_W'(1);
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl)
            AOP_INIT: begin
                r_carry <= i_addend;
                r_rem   <= '0;
            end
            AOP_MUL: begin
                r_prod <= (2*LIMB_W)'(i_rd_data) * (2*LIMB_W)'(i_factor);
            end
            AOP_ACC: begin
                r_carry <= sum[2*LIMB_W-1:LIMB_W];
            end
            AOP_LOAD: begin
                r_dq <= i_rd_data;
            end
            AOP_STEP: begin
                r_rem <= ge ? diff[LIMB_W-1:0] : trial[LIMB_W-1:0];
                r_dq  <= {r_dq[LIMB_W-2:0], ge};
            end
            default: begin
            end
        endcase
    end

    assign o_stat.mul_lo   = sum[LIMB_W-1:0];
    assign o_stat.carry    = r_carry;
    assign o_stat.quo      = r_dq;
    assign o_stat.rem      = r_rem;
    assign o_stat.div_last = (r_step == STEP_W'(LIMB_W - 1));

endmodule

@@ sv/bignum_single_limb_mul_div_unit.sv @@
// ----------------------------------------------------------------------------
// Single-limb multiply-add and divide unit
// Holds one unsigned big integer as 32-bit limbs and applies clear,
// multiply-add, divide-with-remainder and limb-read transactions to it.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy then stays
// high until the result has been formed. Each result appears for exactly one
// cycle with o_done high and cannot be held off, so it must be captured then.
// Clear and an out-of-range read go straight to the result; a limb read first
// waits for the registered store read. Multiply-add makes one pass of the
// shared multiplier over the limb store (multiply, then add carry and write
// back for each limb). Divide runs the bit-serial divider over each limb from
// the top, with a load, the quotient bit steps and a write-back per limb. A
// divide by zero goes straight to the result.
// ----------------------------------------------------------------------------
`include "bignum_single_limb_mul_div_unit_assert.svh"

module bignum_single_limb_mul_div_unit import bsl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     i_op,
    input  logic [LIMB_W-1:0]   i_factor,
    input  logic [LIMB_W-1:0]   i_addend,
    input  logic [INDEX_W-1:0]  i_limb_index,
    output logic                o_done,
    output logic [LIMB_W-1:0]   o_result_value,
    output logic [TOTAL_W-1:0]  o_limb_total,
    output logic [BITLEN_W-1:0] o_bit_length,
    output logic                o_overflow,
    output logic                o_divide_by_zero
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [LIMB_W-1:0]   r_top, n_top;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_hi_any, n_hi_any;
    logic [ADDR_W-1:0]   r_hi_idx, n_hi_idx;
    logic [LIMB_W-1:0]   r_hi_val, n_hi_val;
    logic [LIMB_W-1:0]   r_factor, n_factor;
    logic [LIMB_W-1:0]   r_value, n_value;
    logic                r_ovf, n_ovf;
    logic                r_dbz, n_dbz;

    logic                r_done, n_done;
    logic [LIMB_W-1:0]   r_res_value, n_res_value;
    logic [TOTAL_W-1:0]  r_res_total, n_res_total;
    logic [BITLEN_W-1:0] r_res_bits, n_res_bits;
    logic                r_res_ovf, n_res_ovf;
    logic                r_res_dbz, n_res_dbz;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [LIMB_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [LIMB_W-1:0]   ram_rdata;

    t_arith_op           arith_op;
    t_arith_stat         arith_stat;

    logic [CMP_W-1:0]    idx_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic [BLC_W-1:0]    bits_full;

    assign idx_ext = CMP_W'(i_limb_index);
    assign cnt_ext = CMP_W'(r_count);

    // Bit length of the current number from its count and top limb.
    always_comb begin
        if (r_count == '0) begin
            bits_full = '0;
        end else begin
            bits_full = (BLC_W'(r_count - CNT_W'(1)) << STEP_W)
                      + BLC_W'(limb_bits(r_top));
        end
    end

    bsl_limb_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bsl_arith_unit u_arith (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (arith_op),
        .i_rd_data (ram_rdata),
        .i_factor  (r_factor),
        .i_addend  (i_addend),
        .o_stat    (arith_stat)
    );

    // Sequencer: next state, store access and arithmetic commands.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_top       = r_top;
        n_idx       = r_idx;
        n_hi_any    = r_hi_any;
        n_hi_idx    = r_hi_idx;
        n_hi_val    = r_hi_val;
        n_factor    = r_factor;
        n_value     = r_value;
        n_ovf       = r_ovf;
        n_dbz       = r_dbz;
        n_done      = 1'b0;
        n_res_value = r_res_value;
        n_res_total = r_res_total;
        n_res_bits  = r_res_bits;
        n_res_ovf   = r_res_ovf;
        n_res_dbz   = r_res_dbz;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[ADDR_W-1:0];
        ram_wdata   = arith_stat.mul_lo;
        ram_raddr   = r_idx[ADDR_W-1:0];
        arith_op    = AOP_HOLD;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_factor = i_factor;
                    n_value  = '0;
                    n_ovf    = 1'b0;
                    n_dbz    = 1'b0;
                    n_hi_any = 1'b0;
                    unique case (t_op'(i_op))
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = ST_FIN;
                        end
                        OP_MULADD: begin
                            arith_op  = AOP_INIT;
                            n_idx     = '0;
                            ram_raddr = '0;
                            n_state   = (r_count == '0) ? ST_MUL_TAIL : ST_MUL_MPY;
                        end
                        OP_DIVIDE: begin
                            if (i_factor == '0) begin
                                n_dbz   = 1'b1;
                                n_state = ST_FIN;
                            end else if (r_count == '0) begin
                                n_state = ST_FIN;
                            end else begin
                                arith_op  = AOP_INIT;
                                n_idx     = r_count;
                                ram_raddr = ADDR_W'(r_count - CNT_W'(1));
                                n_state   = ST_DIV_LOAD;
                            end
                        end
                        OP_READ: begin
                            if (idx_ext < cnt_ext) begin
                                ram_raddr = ADDR_W'(i_limb_index);
                                n_state   = ST_RD_WAIT;
                            end else begin
                                n_state = ST_FIN;
                            end
                        end
                    endcase
                end
            end

            // Multiply the limb just read by the factor.
            ST_MUL_MPY: begin
                arith_op = AOP_MUL;
                n_state  = ST_MUL_ACC;
            end

            // Add the carry, write the limb back and fetch the next one.
            ST_MUL_ACC: begin
                arith_op  = AOP_ACC;
                ram_we    = 1'b1;
                ram_waddr = r_idx[ADDR_W-1:0];
                ram_wdata = arith_stat.mul_lo;
                if (arith_stat.mul_lo != '0) begin
                    n_hi_any = 1'b1;
                    n_hi_idx = r_idx[ADDR_W-1:0];
                    n_hi_val = arith_stat.mul_lo;
                end
                n_idx     = r_idx + CNT_W'(1);
                ram_raddr = ADDR_W'(r_idx + CNT_W'(1));
                n_state   = ((r_idx + CNT_W'(1)) < r_count) ? ST_MUL_MPY : ST_MUL_TAIL;
            end

            // Append the final carry as a new top limb if there is room.
            ST_MUL_TAIL: begin
                if ((arith_stat.carry != '0) && (r_count < CNT_W'(LIMB_CAPACITY))) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx[ADDR_W-1:0];
                    ram_wdata = arith_stat.carry;
                    n_count   = r_count + CNT_W'(1);
                    n_top     = arith_stat.carry;
                end else begin
                    n_ovf = (arith_stat.carry != '0);
                    if (r_hi_any) begin
                        n_count = CNT_W'(r_hi_idx) + CNT_W'(1);
                        n_top   = r_hi_val;
                    end else begin
                        n_count = '0;
                    end
                end
                n_state = ST_FIN;
            end

            // Load the next dividend limb into the divider.
            ST_DIV_LOAD: begin
                arith_op = AOP_LOAD;
                n_state  = ST_DIV_STEP;
            end

            ST_DIV_STEP: begin
                arith_op = AOP_STEP;
                if (arith_stat.div_last) begin
                    n_state = ST_DIV_WRITE;
                end
            end

            // Write the quotient limb; the first nonzero one from the top
            // sets the new count.
            ST_DIV_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(r_idx - CNT_W'(1));
                ram_wdata = arith_stat.quo;
                if (!r_hi_any && (arith_stat.quo != '0)) begin
                    n_hi_any = 1'b1;
                    n_hi_idx = ADDR_W'(r_idx - CNT_W'(1));
                    n_hi_val = arith_stat.quo;
                end
                if (r_idx == CNT_W'(1)) begin
                    n_value = arith_stat.rem;
                    if (r_hi_any) begin
                        n_count = CNT_W'(r_hi_idx) + CNT_W'(1);
                        n_top   = r_hi_val;
                    end else if (arith_stat.quo != '0) begin
                        n_count = CNT_W'(1);
                        n_top   = arith_stat.quo;
                    end else begin
                        n_count = '0;
                    end
                    n_state = ST_FIN;
                end else begin
                    ram_raddr = ADDR_W'(r_idx - CNT_W'(2));
                    n_idx     = r_idx - CNT_W'(1);
                    n_state   = ST_DIV_LOAD;
                end
            end

            ST_RD_WAIT: begin
                n_value = ram_rdata;
                n_state = ST_FIN;
            end

            // Form the result transaction.
            ST_FIN: begin
                n_done      = 1'b1;
                n_res_value = r_value;
                n_res_total = TOTAL_W'(r_count);
                n_res_bits  = BITLEN_W'(bits_full);
                n_res_ovf   = r_ovf;
                n_res_dbz   = r_dbz;
                n_state     = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_hi_any  <= 1'b0;
            r_ovf     <= 1'b0;
            r_dbz     <= 1'b0;
            r_done    <= 1'b0;
            r_res_ovf <= 1'b0;
            r_res_dbz <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_hi_any  <= n_hi_any;
            r_ovf     <= n_ovf;
            r_dbz     <= n_dbz;
            r_done    <= n_done;
            r_res_ovf <= n_res_ovf;
            r_res_dbz <= n_res_dbz;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_top       <= n_top;
        r_idx       <= n_idx;
        r_hi_idx    <= n_hi_idx;
        r_hi_val    <= n_hi_val;
        r_factor    <= n_factor;
        r_value     <= n_value;
        r_res_value <= n_res_value;
        r_res_total <= n_res_total;
        r_res_bits  <= n_res_bits;
    end

    assign busy             = (r_state != ST_IDLE);
    assign o_done           = r_done;
    assign o_result_value   = r_res_value;
    assign o_limb_total     = r_res_total;
    assign o_bit_length     = r_res_bits;
    assign o_overflow       = r_res_ovf;
    assign o_divide_by_zero = r_res_dbz;

    // Checks on the sequencer and the kept number.
    `BSL_ASSERT_ALWAYS(a_count_in_range, i_clk, i_rst_n, r_count <= CNT_W'(LIMB_CAPACITY))
    `BSL_ASSERT_ALWAYS(a_top_normalized, i_clk, i_rst_n, (r_state != ST_IDLE) || (r_count == '0) || (r_top != '0))
    `BSL_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `BSL_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `BSL_ASSERT_ALWAYS(a_flags_exclusive, i_clk, i_rst_n, !(o_overflow && o_divide_by_zero))

endmodule
